// File: hw/rtl/polygon_aa_fringe_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polygon fringe generator
// Shared property forms; the using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AA_FRINGE_GENERATOR_TOP_ASSERT_SVH
`define POLYGON_AA_FRINGE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PAFG_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PAFG_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/pafg_pkg.sv
// ----------------------------------------------------------------------------
// pafg_pkg
// Widths, register indexes and record codes of the polygon fringe generator.
// ----------------------------------------------------------------------------
package pafg_pkg;

    localparam int COORD_BITS       = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_W         = 16;
    localparam int INDEX_W          = 16;
    localparam int DEPTH_W          = 32;
    localparam int COLOR_W          = 32;
    localparam int ALPHA_W          = 8;

    // normal datapath
    localparam int NORM_BITS = 24;                            // normalized magnitude width
    localparam int DIFF_W    = COORD_BITS + 1;                // exact coordinate difference
    localparam int ROOT_W    = NORM_BITS + 1;                 // length width
    localparam int SQ_W      = 2 * NORM_BITS + 1;             // sum of squares
    localparam int SU_W      = SQ_W + 1;                      // shared subtractor width
    localparam int NUM_W     = NORM_BITS + NORMAL_FRAC_BITS + 1; // dividend width
    localparam int REM_W     = ROOT_W + 1;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd2;

    // record kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // record slots within one segment
    localparam int REC_W = 4;
    localparam logic [REC_W-1:0] REC_SOLID   = 4'd0;
    localparam logic [REC_W-1:0] REC_FR_S    = 4'd1;
    localparam logic [REC_W-1:0] REC_FR_E    = 4'd2;
    localparam logic [REC_W-1:0] REC_I_OUT0  = 4'd3;
    localparam logic [REC_W-1:0] REC_I_OUT1  = 4'd4;
    localparam logic [REC_W-1:0] REC_I_OUT2  = 4'd5;
    localparam logic [REC_W-1:0] REC_I_IN0   = 4'd6;
    localparam logic [REC_W-1:0] REC_I_IN1   = 4'd7;
    localparam logic [REC_W-1:0] REC_I_IN2   = 4'd8;
    localparam logic [REC_W-1:0] REC_I_JN0   = 4'd9;
    localparam logic [REC_W-1:0] REC_I_JN1   = 4'd10;
    localparam logic [REC_W-1:0] REC_LAST    = 4'd11;

endpackage

// File: hw/rtl/pafg_if.sv
// ----------------------------------------------------------------------------
// pafg channel interfaces
// Vertex input channel and fringe record output channel.
// ----------------------------------------------------------------------------
interface pafg_vertex_if;
    import pafg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  vertex_x;
    logic signed [COORD_BITS-1:0]  vertex_y;
    logic                          closes_polygon;

    modport source (output valid, output vertex_x, output vertex_y,
                    output closes_polygon, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y,
                    input closes_polygon, output ready);
endinterface

interface pafg_record_if;
    import pafg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          item_kind;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic [DEPTH_W-1:0]            vertex_depth;
    logic [COLOR_W-1:0]            vertex_color;
    logic signed [NORMAL_W-1:0]    normal_x;
    logic signed [NORMAL_W-1:0]    normal_y;
    logic [INDEX_W-1:0]            tri_index;
    logic                          last_of_run;
    logic                          short_polygon;

    modport source (output valid, output item_kind, output pos_x, output pos_y,
                    output vertex_depth, output vertex_color, output normal_x,
                    output normal_y, output tri_index, output last_of_run,
                    output short_polygon, input ready);
    modport sink   (input valid, input item_kind, input pos_x, input pos_y,
                    input vertex_depth, input vertex_color, input normal_x,
                    input normal_y, input tri_index, input last_of_run,
                    input short_polygon, output ready);
endinterface

// File: hw/rtl/polygon_aa_fringe_generator_top.sv
// ----------------------------------------------------------------------------
// polygon_aa_fringe_generator_top
// Builds the anti-aliasing fringe mesh of a polygon outline, one vertex item
// at a time, with one shared subtractor under a small sequencer.
// ----------------------------------------------------------------------------
// Each vertex item that completes a segment yields twelve records (three
// vertices, nine indices); the closing vertex yields two segments. The block
// takes one item at a time and is ready only between items. A segment runs
// through the coordinate differences, one-bit normalizing shifts, the two
// squares on the multiplier, 25 square-root steps, two divisions and the
// record output; the differences, the root and the divisions share the one
// compare-subtract unit, and a zero-length segment skips the normal. Record
// output stalls with the sink. A first vertex that opens a polygon is only
// stored, and a short polygon gives a single error record.
`include "polygon_aa_fringe_generator_top_assert.svh"

module polygon_aa_fringe_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pafg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pafg_pkg::CFG_DATA_W-1:0]   cfg_data,
    pafg_vertex_if.sink                       vertices,
    pafg_record_if.source                     records
);
    import pafg_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_DX   = 11'b000_0000_0010,
        ST_DY   = 11'b000_0000_0100,
        ST_NORM = 11'b000_0000_1000,
        ST_SQA  = 11'b000_0001_0000,
        ST_SQB  = 11'b000_0010_0000,
        ST_SQRT = 11'b000_0100_0000,
        ST_DLD  = 11'b000_1000_0000,
        ST_DIV  = 11'b001_0000_0000,
        ST_EMIT = 11'b010_0000_0000,
        ST_ERR  = 11'b100_0000_0000
    } state_t;

    // control and polygon state
    state_t                   state_reg, state_next;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic [COLOR_W-1:0]       color_reg, color_next;
    logic [INDEX_W-1:0]       base_reg, base_next;
    logic [COORD_BITS-1:0]    first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [COORD_BITS-1:0]    prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [INDEX_W-1:0]       seg_cnt_reg, seg_cnt_next;
    logic                     have_first_reg, have_first_next;
    logic                     pend_close_reg, pend_close_next;
    logic                     closing_reg, closing_next;
    logic                     div_sel_reg, div_sel_next;
    logic [CNT_W-1:0]         it_cnt_reg, it_cnt_next;
    logic [REC_W-1:0]         rec_reg, rec_next;
    logic                     out_valid_reg, out_valid_next;

    // datapath
    logic [COORD_BITS-1:0]    cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [DIFF_W-1:0]        a_reg, a_next, b_reg, b_next;
    logic                     negx_reg, negx_next, negy_reg, negy_next;
    logic [SU_W-1:0]          sum_reg, sum_next, root_reg, root_next, bit_reg, bit_next;
    logic [ROOT_W-1:0]        len_reg, len_next, rem_reg, rem_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [NORMAL_W-1:0]      quo_reg, quo_next, va_reg, va_next;
    logic [NORMAL_W-1:0]      nx_reg, nx_next, ny_reg, ny_next;

    // output payload
    logic                     o_kind_reg, o_kind_next;
    logic [COORD_BITS-1:0]    o_px_reg, o_px_next, o_py_reg, o_py_next;
    logic [DEPTH_W-1:0]       o_depth_reg, o_depth_next;
    logic [COLOR_W-1:0]       o_color_reg, o_color_next;
    logic [NORMAL_W-1:0]      o_nx_reg, o_nx_next, o_ny_reg, o_ny_next;
    logic [INDEX_W-1:0]       o_tri_reg, o_tri_next;
    logic                     o_last_reg, o_last_next, o_short_reg, o_short_next;

    // shared compare-subtract unit
    logic [SU_W-1:0]          su_a, su_b, su_res;
    logic [SU_W:0]            su_full;
    logic                     su_ge;

    logic [2*NORM_BITS-1:0]   mul_out;
    logic [NORM_BITS-1:0]     mul_in;
    logic [COORD_BITS-1:0]    seg_sx, seg_sy, seg_ex, seg_ey;
    logic [DIFF_W-1:0]        diff;
    logic [REM_W-1:0]         trial;
    logic [NORMAL_W-1:0]      quo_step;
    logic [NORM_BITS-1:0]     div_mag;
    logic [INDEX_W-1:0]       b0, idx_off;
    logic                     slot_free, accept, m_big, m_low;

    assign su_full = {1'b0, su_a} - {1'b0, su_b};
    assign su_res  = su_full[SU_W-1:0];
    assign su_ge   = ~su_full[SU_W];

    assign mul_in  = (state_reg == ST_SQA) ? a_reg[NORM_BITS-1:0] : b_reg[NORM_BITS-1:0];
    assign mul_out = mul_in * mul_in;

    // segment end points: closing segment runs from the current vertex to the first
    assign seg_sx = closing_reg ? cur_x_reg   : prev_x_reg;
    assign seg_sy = closing_reg ? cur_y_reg   : prev_y_reg;
    assign seg_ex = closing_reg ? first_x_reg : cur_x_reg;
    assign seg_ey = closing_reg ? first_y_reg : cur_y_reg;

    assign diff    = su_res[DIFF_W-1:0];
    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign div_mag = div_sel_reg ? b_reg[NORM_BITS-1:0] : a_reg[NORM_BITS-1:0];
    assign quo_step = {quo_reg[NORMAL_W-2:0], su_ge};

    assign m_big = (|a_reg[DIFF_W-1:NORM_BITS]) | (|b_reg[DIFF_W-1:NORM_BITS]);
    assign m_low = ~a_reg[NORM_BITS-1] & ~b_reg[NORM_BITS-1];

    assign slot_free = ~out_valid_reg | records.ready;
    assign accept    = vertices.valid & vertices.ready;
    assign vertices.ready = (state_reg == ST_IDLE);

    // index offsets of the nine triangle corners
    assign b0 = seg_cnt_reg + {seg_cnt_reg[INDEX_W-2:0], 1'b0};
    always_comb
    begin
        unique case (rec_reg)
            REC_I_OUT0, REC_I_IN0: idx_off = b0;
            REC_I_OUT1:            idx_off = b0 + INDEX_W'(1);
            REC_I_OUT2, REC_I_IN1, REC_I_JN1: idx_off = b0 + INDEX_W'(2);
            REC_I_IN2, REC_I_JN0:  idx_off = closing_reg ? INDEX_W'(0) : b0 + INDEX_W'(3);
            REC_LAST:              idx_off = closing_reg ? INDEX_W'(1) : b0 + INDEX_W'(4);
            default:               idx_off = '0;
        endcase
    end

    // shared unit operand select
    always_comb
    begin
        su_a = '0;
        su_b = '0;
        unique case (state_reg)
            ST_DX:
            begin
                su_a = {{(SU_W-COORD_BITS){seg_ex[COORD_BITS-1]}}, seg_ex};
                su_b = {{(SU_W-COORD_BITS){seg_sx[COORD_BITS-1]}}, seg_sx};
            end
            ST_DY:
            begin
                su_a = {{(SU_W-COORD_BITS){seg_ey[COORD_BITS-1]}}, seg_ey};
                su_b = {{(SU_W-COORD_BITS){seg_sy[COORD_BITS-1]}}, seg_sy};
            end
            ST_SQRT:
            begin
                su_a = sum_reg;
                su_b = root_reg + bit_reg;
            end
            ST_DIV:
            begin
                su_a = SU_W'(trial);
                su_b = SU_W'(len_reg);
            end
            default:
            begin
                su_a = '0;
                su_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        color_next      = color_reg;
        base_next       = base_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        seg_cnt_next    = seg_cnt_reg;
        have_first_next = have_first_reg;
        pend_close_next = pend_close_reg;
        closing_next    = closing_reg;
        div_sel_next    = div_sel_reg;
        it_cnt_next     = it_cnt_reg;
        rec_next        = rec_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        negx_next       = negx_reg;
        negy_next       = negy_reg;
        sum_next        = sum_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        quo_next        = quo_reg;
        va_next         = va_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        out_valid_next  = out_valid_reg & ~records.ready;
        o_kind_next     = o_kind_reg;
        o_px_next       = o_px_reg;
        o_py_next       = o_py_reg;
        o_depth_next    = o_depth_reg;
        o_color_next    = o_color_reg;
        o_nx_next       = o_nx_reg;
        o_ny_next       = o_ny_reg;
        o_tri_next      = o_tri_reg;
        o_last_next     = o_last_reg;
        o_short_next    = o_short_reg;

        // configuration writes; unknown indexes are dropped
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEPTH: depth_next = cfg_data[DEPTH_W-1:0];
                CFG_COLOR: color_next = cfg_data[COLOR_W-1:0];
                CFG_BASE:  base_next  = cfg_data[INDEX_W-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_x_next   = vertices.vertex_x;
                    cur_y_next   = vertices.vertex_y;
                    closing_next = 1'b0;
                    if (vertices.closes_polygon)
                    begin
                        pend_close_next = 1'b1;
                        if (!have_first_reg || seg_cnt_reg == '0)
                            state_next = ST_ERR;
                        else
                            state_next = ST_DX;
                    end
                    else if (!have_first_reg)
                    begin
                        // opening vertex: stored only
                        first_x_next    = vertices.vertex_x;
                        first_y_next    = vertices.vertex_y;
                        prev_x_next     = vertices.vertex_x;
                        prev_y_next     = vertices.vertex_y;
                        seg_cnt_next    = '0;
                        have_first_next = 1'b1;
                    end
                    else
                    begin
                        pend_close_next = 1'b0;
                        state_next      = ST_DX;
                    end
                end
            end
            ST_DX:
            begin
                negx_next  = diff[DIFF_W-1];
                a_next     = diff[DIFF_W-1] ? DIFF_W'(0) - diff : diff;
                state_next = ST_DY;
            end
            ST_DY:
            begin
                negy_next  = diff[DIFF_W-1];
                b_next     = diff[DIFF_W-1] ? DIFF_W'(0) - diff : diff;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // one-bit shifts until the larger magnitude has NORM_BITS bits
                if (a_reg == '0 && b_reg == '0)
                begin
                    nx_next    = '0;
                    ny_next    = '0;
                    rec_next   = REC_SOLID;
                    state_next = ST_EMIT;
                end
                else if (m_big)
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                else if (m_low)
                begin
                    a_next = a_reg << 1;
                    b_next = b_reg << 1;
                end
                else
                begin
                    state_next = ST_SQA;
                end
            end
            ST_SQA:
            begin
                sum_next   = SU_W'(mul_out);
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                sum_next    = sum_reg + SU_W'(mul_out);
                root_next   = '0;
                bit_next    = SU_W'(1) << (2 * NORM_BITS);
                it_cnt_next = '0;
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                // one root digit per cycle
                if (su_ge)
                begin
                    sum_next  = su_res;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next    = bit_reg >> 2;
                it_cnt_next = it_cnt_reg + CNT_W'(1);
                if (it_cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    len_next     = root_next[ROOT_W-1:0];
                    div_sel_next = 1'b0;
                    state_next   = ST_DLD;
                end
            end
            ST_DLD:
            begin
                num_next    = NUM_W'({div_mag, {NORMAL_FRAC_BITS{1'b0}}})
                            + NUM_W'(len_reg >> 1);
                rem_next    = '0;
                quo_next    = '0;
                it_cnt_next = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next    = su_ge ? su_res[ROOT_W-1:0] : trial[ROOT_W-1:0];
                quo_next    = quo_step;
                num_next    = num_reg << 1;
                it_cnt_next = it_cnt_reg + CNT_W'(1);
                if (it_cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    if (!div_sel_reg)
                    begin
                        va_next      = quo_step;
                        div_sel_next = 1'b1;
                        state_next   = ST_DLD;
                    end
                    else
                    begin
                        nx_next    = negy_reg ? NORMAL_W'(0) - quo_step : quo_step;
                        ny_next    = negx_reg ? va_reg : NORMAL_W'(0) - va_reg;
                        rec_next   = REC_SOLID;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_short_next   = 1'b0;
                    o_last_next    = (rec_reg == REC_LAST) && !pend_close_reg;
                    if (rec_reg == REC_SOLID || rec_reg == REC_FR_S || rec_reg == REC_FR_E)
                    begin
                        o_kind_next  = KIND_VERTEX;
                        o_px_next    = (rec_reg == REC_FR_E) ? seg_ex : seg_sx;
                        o_py_next    = (rec_reg == REC_FR_E) ? seg_ey : seg_sy;
                        o_depth_next = depth_reg;
                        o_color_next = (rec_reg == REC_SOLID) ? color_reg
                                     : {color_reg[COLOR_W-1:ALPHA_W], {ALPHA_W{1'b0}}};
                        o_nx_next    = (rec_reg == REC_SOLID) ? '0 : nx_reg;
                        o_ny_next    = (rec_reg == REC_SOLID) ? '0 : ny_reg;
                        o_tri_next   = '0;
                    end
                    else
                    begin
                        o_kind_next  = KIND_INDEX;
                        o_px_next    = '0;
                        o_py_next    = '0;
                        o_depth_next = '0;
                        o_color_next = '0;
                        o_nx_next    = '0;
                        o_ny_next    = '0;
                        o_tri_next   = base_reg + idx_off;
                    end
                    rec_next = rec_reg + REC_W'(1);
                    if (rec_reg == REC_LAST)
                    begin
                        seg_cnt_next = seg_cnt_reg + INDEX_W'(1);
                        if (pend_close_reg)
                        begin
                            pend_close_next = 1'b0;
                            closing_next    = 1'b1;
                            state_next      = ST_DX;
                        end
                        else if (closing_reg)
                        begin
                            closing_next    = 1'b0;
                            first_x_next    = '0;
                            first_y_next    = '0;
                            prev_x_next     = '0;
                            prev_y_next     = '0;
                            seg_cnt_next    = '0;
                            have_first_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            prev_x_next = cur_x_reg;
                            prev_y_next = cur_y_reg;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    o_kind_next     = KIND_VERTEX;
                    o_px_next       = '0;
                    o_py_next       = '0;
                    o_depth_next    = '0;
                    o_color_next    = '0;
                    o_nx_next       = '0;
                    o_ny_next       = '0;
                    o_tri_next      = '0;
                    o_last_next     = 1'b1;
                    o_short_next    = 1'b1;
                    pend_close_next = 1'b0;
                    first_x_next    = '0;
                    first_y_next    = '0;
                    prev_x_next     = '0;
                    prev_y_next     = '0;
                    seg_cnt_next    = '0;
                    have_first_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            color_reg      <= '1;
            base_reg       <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            seg_cnt_reg    <= '0;
            have_first_reg <= 1'b0;
            pend_close_reg <= 1'b0;
            closing_reg    <= 1'b0;
            div_sel_reg    <= 1'b0;
            it_cnt_reg     <= '0;
            rec_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            color_reg      <= color_next;
            base_reg       <= base_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            seg_cnt_reg    <= seg_cnt_next;
            have_first_reg <= have_first_next;
            pend_close_reg <= pend_close_next;
            closing_reg    <= closing_next;
            div_sel_reg    <= div_sel_next;
            it_cnt_reg     <= it_cnt_next;
            rec_reg        <= rec_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath and payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        sum_reg     <= sum_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        va_reg      <= va_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        o_kind_reg  <= o_kind_next;
        o_px_reg    <= o_px_next;
        o_py_reg    <= o_py_next;
        o_depth_reg <= o_depth_next;
        o_color_reg <= o_color_next;
        o_nx_reg    <= o_nx_next;
        o_ny_reg    <= o_ny_next;
        o_tri_reg   <= o_tri_next;
        o_last_reg  <= o_last_next;
        o_short_reg <= o_short_next;
    end

    assign records.valid         = out_valid_reg;
    assign records.item_kind     = o_kind_reg;
    assign records.pos_x         = o_px_reg;
    assign records.pos_y         = o_py_reg;
    assign records.vertex_depth  = o_depth_reg;
    assign records.vertex_color  = o_color_reg;
    assign records.normal_x      = o_nx_reg;
    assign records.normal_y      = o_ny_reg;
    assign records.tri_index     = o_tri_reg;
    assign records.last_of_run   = o_last_reg;
    assign records.short_polygon = o_short_reg;

    // checks
    `PAFG_ASSERT_IMP(a_short_is_last, records.valid && records.short_polygon, records.last_of_run, "error record without end of run")
    `PAFG_ASSERT_IMP(a_rec_range, state_reg == ST_EMIT, rec_reg <= REC_LAST, "record slot out of range")
    `PAFG_ASSERT_NXT(a_seg_start, accept && (have_first_reg || vertices.closes_polygon), state_reg == ST_DX || state_reg == ST_ERR, "segment item did not start work")
    `PAFG_ASSERT_IMP(a_len_norm, state_reg == ST_DLD, len_reg[ROOT_W-1:NORM_BITS-1] != '0, "length not normalized")

endmodule
